@@ hw/rtl/mas_pkg.sv @@
// Shared types and constants for the matrix add/subtract/multiply block.
// No dependencies.
package mas_pkg;

    localparam int ELEM_W = 16;
    localparam int SUM_W  = 17;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 34;
    localparam int IDX_W  = 3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_FLUSH
    } state_t;

endpackage

@@ hw/rtl/mas_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/matrix_add_sub_multiply.sv @@
// Matrix add/subtract/multiply top level; uses mas_pkg and mas_ram.
// Load takes N*N words, one per cycle. Each result then sums N products,
// one multiply-accumulate per cycle unless out_stall holds the pipeline,
// bound by the single read port of each RAM.
// Reset clears control state only; the matrix RAMs are not cleared.
module matrix_add_sub_multiply #(
    parameter int MATRIX_SIZE = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [mas_pkg::ELEM_W-1:0] a_value,
    input  logic signed [mas_pkg::ELEM_W-1:0] b_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mas_pkg::IDX_W-1:0]         row_index,
    output logic [mas_pkg::IDX_W-1:0]         col_index,
    output logic signed [mas_pkg::SUM_W-1:0]  sum_value,
    output logic signed [mas_pkg::SUM_W-1:0]  diff_value,
    output logic signed [mas_pkg::PROD_W-1:0] product_value,
    output logic                              last_result
);

    localparam int DEPTH = MATRIX_SIZE * MATRIX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MATRIX_SIZE);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [IW-1:0] IDX_MAX  = IW'(MATRIX_SIZE - 1);
    localparam logic [AW-1:0] STRIDE   = AW'(MATRIX_SIZE);

    mas_pkg::state_t state_reg, state_next;

    logic [AW-1:0] load_cnt_reg;
    logic [IW-1:0] r_reg, c_reg, k_reg;
    logic [AW-1:0] row_base_reg, k_base_reg;

    logic                              s1_valid_reg, s1_first_reg, s1_last_reg;
    logic                              s1_cap_a_reg, s1_cap_b_reg, s1_final_reg;
    logic [IW-1:0]                     s1_row_reg, s1_col_reg;
    logic                              s2_valid_reg, s2_first_reg, s2_last_reg;
    logic                              s2_final_reg;
    logic [IW-1:0]                     s2_row_reg, s2_col_reg;
    logic signed [mas_pkg::MUL_W-1:0]  prod_reg;
    logic signed [mas_pkg::ELEM_W-1:0] s2_a_reg, s2_b_reg;
    logic signed [mas_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic                              out_valid_reg;

    logic                              adv, issue, load_we, load_done, run_done;
    logic [AW-1:0]                     addr_a, addr_b;
    logic [mas_pkg::ELEM_W-1:0]        rdata_a, rdata_b;
    logic signed [mas_pkg::ELEM_W-1:0] rd_a, rd_b;
    logic                              k_end, c_end, r_end, s2_done;

    assign load_we   = (state_reg == mas_pkg::ST_LOAD) && in_valid;
    assign load_done = load_we && (load_cnt_reg == LAST_POS);
    assign adv       = !(s2_valid_reg && s2_last_reg && out_valid_reg && out_stall);
    assign issue     = (state_reg == mas_pkg::ST_RUN) && adv;
    assign k_end     = (k_reg == IDX_MAX);
    assign c_end     = (c_reg == IDX_MAX);
    assign r_end     = (r_reg == IDX_MAX);
    assign run_done  = issue && k_end && c_end && r_end;
    assign s2_done   = adv && s2_valid_reg && s2_last_reg;
    assign addr_a    = row_base_reg + AW'(k_reg);
    assign addr_b    = k_base_reg + AW'(c_reg);
    assign rd_a      = $signed(rdata_a);
    assign rd_b      = $signed(rdata_b);

    mas_ram #(
        .WIDTH (mas_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_cnt_reg),
        .wdata (a_value),
        .re    (issue),
        .raddr (addr_a),
        .rdata (rdata_a)
    );

    mas_ram #(
        .WIDTH (mas_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_cnt_reg),
        .wdata (b_value),
        .re    (issue),
        .raddr (addr_b),
        .rdata (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mas_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            mas_pkg::ST_LOAD:
            begin
                in_stall = 1'b0;
                if (load_done)
                begin
                    state_next = mas_pkg::ST_RUN;
                end
            end
            mas_pkg::ST_RUN:
            begin
                if (run_done)
                begin
                    state_next = mas_pkg::ST_FLUSH;
                end
            end
            mas_pkg::ST_FLUSH:
            begin
                if (s2_done && s2_final_reg)
                begin
                    state_next = mas_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mas_pkg::ST_LOAD;
            end
        endcase
    end

    // load counter and read sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            k_base_reg   <= '0;
        end
        else
        begin
            if (load_we)
            begin
                load_cnt_reg <= load_done ? '0 : load_cnt_reg + AW'(1);
            end
            if (load_done)
            begin
                r_reg        <= '0;
                c_reg        <= '0;
                k_reg        <= '0;
                row_base_reg <= '0;
                k_base_reg   <= '0;
            end
            else if (issue)
            begin
                if (k_end)
                begin
                    k_reg      <= '0;
                    k_base_reg <= '0;
                    if (c_end)
                    begin
                        c_reg        <= '0;
                        r_reg        <= r_reg + IW'(1);
                        row_base_reg <= row_base_reg + STRIDE;
                    end
                    else
                    begin
                        c_reg <= c_reg + IW'(1);
                    end
                end
                else
                begin
                    k_reg      <= k_reg + IW'(1);
                    k_base_reg <= k_base_reg + STRIDE;
                end
            end
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        acc_next = (s2_first_reg ? '0 : acc_reg) + mas_pkg::PROD_W'(prod_reg);
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_first_reg <= (k_reg == '0);
            s1_last_reg  <= k_end;
            s1_cap_a_reg <= (k_reg == c_reg);
            s1_cap_b_reg <= (k_reg == r_reg);
            s1_final_reg <= k_end && c_end && r_end;
            s1_row_reg   <= r_reg;
            s1_col_reg   <= c_reg;

            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_final_reg <= s1_final_reg;
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            prod_reg     <= rd_a * rd_b;
            if (s1_valid_reg && s1_cap_a_reg)
            begin
                s2_a_reg <= rd_a;
            end
            if (s1_valid_reg && s1_cap_b_reg)
            begin
                s2_b_reg <= rd_b;
            end
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
        if (s2_done)
        begin
            row_index     <= mas_pkg::IDX_W'(s2_row_reg);
            col_index     <= mas_pkg::IDX_W'(s2_col_reg);
            sum_value     <= mas_pkg::SUM_W'(s2_a_reg) + mas_pkg::SUM_W'(s2_b_reg);
            diff_value    <= mas_pkg::SUM_W'(s2_a_reg) - mas_pkg::SUM_W'(s2_b_reg);
            product_value <= acc_next;
            last_result   <= s2_final_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sim/tb_matrix_add_sub_multiply.sv @@
// Testbench for matrix_add_sub_multiply: loads pairs of 4x4 matrices and checks every
// result element (sum, difference, product entry) against an in-bench matrix model.
// Depends on mas_pkg and the RTL of the block.
module tb_matrix_add_sub_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N          = 4;
    localparam int ELEMS      = N * N;
    localparam int DIR_WORDS  = 25;
    localparam int RAND_WORDS = 17 * ELEMS - DIR_WORDS;
    localparam int HOLD_CYC   = 400;
    localparam int DRAIN_CYC  = 4 * N + 40;
    localparam int LIMIT_CYC  = 60000;

    typedef struct {
        logic signed [mas_pkg::ELEM_W-1:0] a;
        logic signed [mas_pkg::ELEM_W-1:0] b;
        bit                                typed;
        logic signed [mas_pkg::SUM_W-1:0]  sum;
        logic signed [mas_pkg::SUM_W-1:0]  diff;
        logic signed [mas_pkg::PROD_W-1:0] prod;
    } pair_word_t;

    typedef struct {
        logic [mas_pkg::IDX_W-1:0]         row;
        logic [mas_pkg::IDX_W-1:0]         col;
        logic signed [mas_pkg::SUM_W-1:0]  sum;
        logic signed [mas_pkg::SUM_W-1:0]  diff;
        logic signed [mas_pkg::PROD_W-1:0] prod;
        logic                              last;
    } elem_result_t;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [mas_pkg::ELEM_W-1:0]  a_value;
    logic signed [mas_pkg::ELEM_W-1:0]  b_value;
    logic                               out_valid;
    logic                               out_stall;
    logic [mas_pkg::IDX_W-1:0]          row_index;
    logic [mas_pkg::IDX_W-1:0]          col_index;
    logic signed [mas_pkg::SUM_W-1:0]   sum_value;
    logic signed [mas_pkg::SUM_W-1:0]   diff_value;
    logic signed [mas_pkg::PROD_W-1:0]  product_value;
    logic                               last_result;

    pair_word_t   dir_tab [DIR_WORDS];
    pair_word_t   loaded [ELEMS];
    elem_result_t pending_elems [$];
    int           fill_cnt;
    int           err_cnt;
    int           words_sent;
    int           elems_checked;
    int           loads_done;
    int           cycle_cnt;
    bit           idle_on;
    bit           hold_req;

    matrix_add_sub_multiply #(
        .MATRIX_SIZE (N)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .a_value       (a_value),
        .b_value       (b_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_index     (row_index),
        .col_index     (col_index),
        .sum_value     (sum_value),
        .diff_value    (diff_value),
        .product_value (product_value),
        .last_result   (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // matrix model: store the pair, emit the whole result run on the final pair
    task automatic load_pair(input pair_word_t w);
        elem_result_t res;
        longint       acc;
        int           p;
        begin
            loaded[fill_cnt] = w;
            fill_cnt++;
            if (fill_cnt == ELEMS)
            begin
                fill_cnt = 0;
                loads_done++;
                for (int r = 0; r < N; r++)
                begin
                    for (int c = 0; c < N; c++)
                    begin
                        p   = r * N + c;
                        acc = 0;
                        for (int k = 0; k < N; k++)
                            acc += longint'(loaded[r*N+k].a) * longint'(loaded[k*N+c].b);
                        res.row  = mas_pkg::IDX_W'(r);
                        res.col  = mas_pkg::IDX_W'(c);
                        res.sum  = loaded[p].a + loaded[p].b;
                        res.diff = loaded[p].a - loaded[p].b;
                        res.prod = mas_pkg::PROD_W'(acc);
                        res.last = (p == ELEMS - 1);
                        if (loaded[p].typed)
                        begin
                            res.sum  = loaded[p].sum;
                            res.diff = loaded[p].diff;
                            res.prod = loaded[p].prod;
                        end
                        pending_elems.push_back(res);
                    end
                end
            end
        end
    endtask

    task automatic drive_word(input pair_word_t w);
        begin
            while (idle_on && $urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            a_value  <= w.a;
            b_value  <= w.b;
            do @(posedge clk); while (in_stall);
            load_pair(w);
            words_sent++;
        end
    endtask

    function automatic logic signed [mas_pkg::ELEM_W-1:0] rand_elem(input int mode);
        logic signed [mas_pkg::ELEM_W-1:0] v;
        begin
            if (mode == 0)
                v = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            else
            begin
                case ($urandom_range(9))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = '0;
                    3:       v = -16'sd1;
                    4:       v = mas_pkg::ELEM_W'($urandom_range(0, 15)) - 16'sd8;
                    default: v = mas_pkg::ELEM_W'($urandom);
                endcase
            end
            return v;
        end
    endfunction

    // output side: random stall plus one long hold-off
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYC - 1) @(posedge clk);
            end
            else
                out_stall <= idle_on && ($urandom_range(99) < 19);
        end
    end

    initial
    begin
        elem_result_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_elems.size() == 0)
                begin
                    $error("unexpected result word: row %0d col %0d", row_index, col_index);
                    err_cnt++;
                end
                else
                begin
                    e = pending_elems.pop_front();
                    elems_checked++;
                    if (row_index !== e.row)
                    begin
                        $error("row_index: expected %0d, got %0d", e.row, row_index);
                        err_cnt++;
                    end
                    if (col_index !== e.col)
                    begin
                        $error("col_index: expected %0d, got %0d", e.col, col_index);
                        err_cnt++;
                    end
                    if (sum_value !== e.sum)
                    begin
                        $error("sum_value: expected %0d, got %0d", e.sum, sum_value);
                        err_cnt++;
                    end
                    if (diff_value !== e.diff)
                    begin
                        $error("diff_value: expected %0d, got %0d", e.diff, diff_value);
                        err_cnt++;
                    end
                    if (product_value !== e.prod)
                    begin
                        $error("product_value: expected %0d, got %0d", e.prod, product_value);
                        err_cnt++;
                    end
                    if (last_result !== e.last)
                    begin
                        $error("last_result: expected %0d, got %0d", e.last, last_result);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > LIMIT_CYC)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        pair_word_t w;
        int         mode;
        fill_cnt      = 0;
        err_cnt       = 0;
        words_sent    = 0;
        elems_checked = 0;
        loads_done    = 0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        mode          = 1;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        a_value  <= '0;
        b_value  <= '0;

        // first load: every element -32768, so sum -65536, diff 0, product 2^32
        for (int i = 0; i < ELEMS; i++)
            dir_tab[i] = '{16'sh8000, 16'sh8000, 1'b1, 17'h1_0000, 17'h0_0000, 34'h1_0000_0000};
        dir_tab[16] = '{16'sh7FFF, 16'sh7FFF, 1'b0, '0, '0, '0};
        dir_tab[17] = '{16'sh7FFF, 16'sh8000, 1'b0, '0, '0, '0};
        dir_tab[18] = '{16'sh8000, 16'sh7FFF, 1'b0, '0, '0, '0};
        dir_tab[19] = '{16'sh0000, 16'sh0000, 1'b0, '0, '0, '0};
        dir_tab[20] = '{16'shFFFF, 16'shFFFF, 1'b0, '0, '0, '0};
        dir_tab[21] = '{16'sh0001, 16'shFFFF, 1'b0, '0, '0, '0};
        dir_tab[22] = '{16'sh5555, 16'shAAAA, 1'b0, '0, '0, '0};
        dir_tab[23] = '{16'shAAAA, 16'sh5555, 1'b0, '0, '0, '0};
        dir_tab[24] = '{16'shFFFF, 16'sh0000, 1'b0, '0, '0, '0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        for (int i = 0; i < DIR_WORDS; i++)
            drive_word(dir_tab[i]);

        for (int i = 0; i < RAND_WORDS; i++)
        begin
            idle_on = !(i >= 100 && i < 170);
            if (i == 40)
                hold_req = 1'b1;
            if (fill_cnt == 0)
                mode = $urandom_range(7);
            w.a     = rand_elem(mode);
            w.b     = rand_elem(mode);
            w.typed = 1'b0;
            w.sum   = '0;
            w.diff  = '0;
            w.prod  = '0;
            drive_word(w);
        end
        in_valid <= 1'b0;

        while (pending_elems.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Covered %0d pair words in %0d full loads, %0d result elements compared.",
                 words_sent, loads_done, elems_checked);
        if (err_cnt == 0 && pending_elems.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mas_pkg.sv
hw/rtl/mas_ram.sv
hw/rtl/matrix_add_sub_multiply.sv
sim/tb_matrix_add_sub_multiply.sv
